### rtl/core/lru_key_value_cache_defines.svh
// Assertion macros shared by the cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define LKV_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define LKV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define LKV_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define LKV_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/core/lkv_pkg.sv
// Types and constants of the LRU key-value cache.
package lkv_pkg;

   localparam int ENTRIES    = 16;
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int IDX_BITS   = $clog2(ENTRIES);
   localparam int CNT_BITS   = 5;

   localparam logic [CNT_BITS-1:0] CAP_RESET = CNT_BITS'(ENTRIES);
   localparam logic [CNT_BITS-1:0] CAP_MIN   = CNT_BITS'(1);
   localparam logic [CNT_BITS-1:0] CAP_MAX   = CNT_BITS'(ENTRIES);

   // Value returned on a miss and on every store
   localparam logic [VALUE_BITS-1:0] MISS_VALUE = '1;

   typedef enum logic {
      KIND_LOOKUP = 1'b0,
      KIND_STORE  = 1'b1
   } kind_type;

   typedef logic [IDX_BITS-1:0] idx_type;
   typedef logic [IDX_BITS-1:0] rank_type;

   typedef struct packed {
      logic                         found;
      logic signed [VALUE_BITS-1:0] read_value;
      logic                         evicted;
      logic signed [31:0]           evicted_key;
   } result_type;

endpackage

### rtl/core/lru_key_value_cache.sv
// Fully associative LRU key-value cache, top level.
// One transaction per cycle unless stalled: a request is taken into an input register;
// from there a single pass of logic compares its key against all 16 entries in parallel,
// updates values, valid bits and recency ranks, and loads the result into a two-deep
// output buffer whose head register drives the response. The request side is stalled
// only while both output slots are held by a stalled response side. The capacity
// register (1..16, reset 16, saturated on write) is taken only while the cache is empty.
`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_kind,
   input  logic signed [31:0]                    req_lookup_key,
   input  logic signed [31:0]                    req_write_value,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_found,
   output logic signed [31:0]                    rsp_read_value,
   output logic                                  rsp_evicted,
   output logic signed [31:0]                    rsp_evicted_key,
   // capacity register
   input  logic                                  csr_write_enable,
   input  logic [lkv_pkg::CNT_BITS-1:0]          csr_write_data
);

   localparam int N = lkv_pkg::ENTRIES;

   // input register
   logic                                 in_valid_ff, in_valid_in;
   logic                                 in_kind_ff;
   logic [lkv_pkg::KEY_BITS-1:0]         in_key_ff;
   logic [lkv_pkg::VALUE_BITS-1:0]       in_value_ff;

   // cache state
   logic [lkv_pkg::KEY_BITS-1:0]         keys_ff   [N];
   logic [lkv_pkg::VALUE_BITS-1:0]       values_ff [N];
   logic [N-1:0]                         valid_ff, valid_in;
   lkv_pkg::rank_type                    rank_ff   [N];
   lkv_pkg::rank_type                    rank_in   [N];
   logic [lkv_pkg::CNT_BITS-1:0]         count_ff, count_in;
   logic [lkv_pkg::CNT_BITS-1:0]         capacity_ff, capacity_in;

   // output buffer: head drives the ports, skid holds the second result
   logic                                 head_valid_ff, head_valid_in;
   logic                                 skid_valid_ff, skid_valid_in;
   lkv_pkg::result_type                  head_ff, head_in;
   lkv_pkg::result_type                  skid_ff, skid_in;

   // datapath
   logic                                 accept;
   logic                                 fire;
   logic                                 pop;
   logic                                 is_store;
   logic [N-1:0]                         match;
   logic                                 hit;
   lkv_pkg::idx_type                     hit_idx;
   logic                                 full;
   logic [lkv_pkg::CNT_BITS-1:0]         oldest_rank;
   logic                                 victim_ok;
   lkv_pkg::idx_type                     victim_idx;
   lkv_pkg::idx_type                     free_idx;
   lkv_pkg::idx_type                     slot_idx;
   lkv_pkg::idx_type                     wr_idx;
   logic                                 evict;
   logic                                 insert;
   logic                                 touch;
   lkv_pkg::rank_type                    touch_rank;
   lkv_pkg::result_type                  result;

   // handshake
   assign fire      = in_valid_ff && !skid_valid_ff;
   assign req_stall = in_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;
   assign pop       = head_valid_ff && !rsp_stall;
   assign in_valid_in = req_stall ? 1'b1 : req_valid;

   // parallel key compare with first-match priority
   always_comb begin
      hit_idx = '0;
      for (int i = N - 1; i >= 0; i--) begin
         match[i] = valid_ff[i] && (keys_ff[i] == in_key_ff);
         if (match[i]) begin
            hit_idx = lkv_pkg::idx_type'(i);
         end
      end
   end
   assign hit = |match;

   // victim and free slot search
   assign full        = count_ff >= capacity_ff;
   assign oldest_rank = count_ff - lkv_pkg::CNT_BITS'(1);
   always_comb begin
      victim_ok  = 1'b0;
      victim_idx = '0;
      free_idx   = '0;
      for (int i = N - 1; i >= 0; i--) begin
         if (valid_ff[i] && ({1'b0, rank_ff[i]} == oldest_rank)) begin
            victim_ok  = 1'b1;
            victim_idx = lkv_pkg::idx_type'(i);
         end
         if (!valid_ff[i]) begin
            free_idx = lkv_pkg::idx_type'(i);
         end
      end
   end

   assign is_store   = (lkv_pkg::kind_type'(in_kind_ff) == lkv_pkg::KIND_STORE);
   assign evict      = fire && is_store && !hit && full && victim_ok;
   assign insert     = fire && is_store && !hit;
   assign touch      = fire && hit;
   assign slot_idx   = evict ? victim_idx : free_idx;
   assign wr_idx     = hit ? hit_idx : slot_idx;
   assign touch_rank = rank_ff[hit_idx];

   // valid, rank and count updates
   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      for (int i = 0; i < N; i++) begin
         rank_in[i] = rank_ff[i];
         if (touch) begin
            if (lkv_pkg::idx_type'(i) == hit_idx) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && (rank_ff[i] < touch_rank)) begin
               rank_in[i] = rank_ff[i] + lkv_pkg::rank_type'(1);
            end
         end else if (insert) begin
            if (lkv_pkg::idx_type'(i) == slot_idx) begin
               rank_in[i] = '0;
            end else if (valid_ff[i]) begin
               rank_in[i] = rank_ff[i] + lkv_pkg::rank_type'(1);
            end
         end
      end
      if (insert) begin
         valid_in[slot_idx] = 1'b1;
         if (!evict) begin
            count_in = count_ff + lkv_pkg::CNT_BITS'(1);
         end
      end
   end

   // capacity write, saturated, only while empty
   always_comb begin
      capacity_in = capacity_ff;
      if (csr_write_enable && (count_ff == '0)) begin
         if (csr_write_data < lkv_pkg::CAP_MIN) begin
            capacity_in = lkv_pkg::CAP_MIN;
         end else if (csr_write_data > lkv_pkg::CAP_MAX) begin
            capacity_in = lkv_pkg::CAP_MAX;
         end else begin
            capacity_in = csr_write_data;
         end
      end
   end

   // result of this transaction
   always_comb begin
      result.found       = hit;
      result.read_value  = (!is_store && hit) ? values_ff[hit_idx] : lkv_pkg::MISS_VALUE;
      result.evicted     = evict;
      result.evicted_key = evict ? 32'(keys_ff[victim_idx]) : '0;
   end

   // two-deep output buffer
   always_comb begin
      head_in       = head_ff;
      skid_in       = skid_ff;
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            skid_valid_in = fire;
            skid_in       = result;
         end else begin
            head_valid_in = fire;
            head_in       = result;
         end
      end else if (!head_valid_ff) begin
         head_valid_in = fire;
         head_in       = result;
      end else if (fire) begin
         skid_valid_in = 1'b1;
         skid_in       = result;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         valid_ff      <= '0;
         count_ff      <= '0;
         capacity_ff   <= lkv_pkg::CAP_RESET;
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
         for (int i = 0; i < N; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         in_valid_ff   <= in_valid_in;
         valid_ff      <= valid_in;
         count_ff      <= count_in;
         capacity_ff   <= capacity_in;
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
         for (int i = 0; i < N; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_kind_ff  <= req_kind;
         in_key_ff   <= lkv_pkg::KEY_BITS'(req_lookup_key);
         in_value_ff <= req_write_value;
      end
      if (fire && is_store) begin
         values_ff[wr_idx] <= in_value_ff;
         if (!hit) begin
            keys_ff[wr_idx] <= in_key_ff;
         end
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = head_valid_ff;
   assign rsp_found       = head_ff.found;
   assign rsp_read_value  = head_ff.read_value;
   assign rsp_evicted     = head_ff.evicted;
   assign rsp_evicted_key = head_ff.evicted_key;

   // checks
   `LKV_ASSERT_IMPLY(a_count_le_cap, clock, reset, 1'b1, count_ff <= capacity_ff)
   `LKV_ASSERT_IMPLY(a_count_valid, clock, reset, 1'b1, $countones(valid_ff) == count_ff)
   `LKV_ASSERT_IMPLY(a_skid_has_head, clock, reset, skid_valid_ff, head_valid_ff)
   `LKV_ASSERT_NEXT(a_evict_keeps_count, clock, reset, evict, count_ff == $past(count_ff))

endmodule

### tb/tb_lru_key_value_cache.sv
// Self-checking testbench for the LRU key-value cache: directed table, then random phases.
`timescale 1ns / 100ps

module tb_lru_key_value_cache;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_PAD   = 6;
   localparam int PHASE_ITEMS = 163;
   localparam int HOLD_CYCLES = 60;

   // directed stimulus row: optional capacity write before the transaction
   typedef struct {
      bit                           cfg_write;
      logic [lkv_pkg::CNT_BITS-1:0] cfg_data;
      lkv_pkg::kind_type            kind;
      logic [31:0]                  key;
      logic [31:0]                  value;
      bit                           typed;
      lkv_pkg::result_type          want;
   } dir_row_type;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic                         req_kind;
   logic signed [31:0]           req_lookup_key;
   logic signed [31:0]           req_write_value;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic                         rsp_found;
   logic signed [31:0]           rsp_read_value;
   logic                         rsp_evicted;
   logic signed [31:0]           rsp_evicted_key;
   logic                         csr_write_enable;
   logic [lkv_pkg::CNT_BITS-1:0] csr_write_data;

   // shadow copy of the cache contents and recency order
   logic [31:0]         shadow_key   [lkv_pkg::ENTRIES];
   logic [31:0]         shadow_value [lkv_pkg::ENTRIES];
   bit                  shadow_live  [lkv_pkg::ENTRIES];
   int                  shadow_age   [lkv_pkg::ENTRIES];
   int                  shadow_fill;
   int                  shadow_capacity;

   lkv_pkg::result_type pending_results [$];
   dir_row_type         dir_rows [$];
   lkv_pkg::result_type resp_want;
   logic [31:0]         key_pool [20];
   int                  pool_size;
   int                  mismatch_count = 0;
   int                  cycle_count    = 0;
   int                  stall_pct      = 0;
   int                  hold_token     = 0;
   int                  hold_seen      = 0;
   int                  hold_left      = 0;

   lru_key_value_cache DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_lookup_key   (req_lookup_key),
      .req_write_value  (req_write_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_read_value   (rsp_read_value),
      .rsp_evicted      (rsp_evicted),
      .rsp_evicted_key  (rsp_evicted_key),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s: got %h, expected %h (t=%0t)", field, got, want, $time);
      mismatch_count++;
   endtask

   // entry s becomes most recent; younger valid entries age by one
   function automatic void make_newest(input int s);
      int old_age;
      old_age = shadow_age[s];
      for (int i = 0; i < lkv_pkg::ENTRIES; i++)
         if (shadow_live[i] && shadow_age[i] < old_age) shadow_age[i]++;
      shadow_age[s] = 0;
   endfunction

   function automatic void shadow_capacity_write(input logic [lkv_pkg::CNT_BITS-1:0] data);
      // ignored once anything is cached; saturated to 1..ENTRIES
      if (shadow_fill != 0) return;
      if (data < 1) shadow_capacity = 1;
      else if (data > lkv_pkg::ENTRIES) shadow_capacity = lkv_pkg::ENTRIES;
      else shadow_capacity = data;
   endfunction

   // computes the response of one transaction and updates the shadow cache
   function automatic lkv_pkg::result_type predict_access(input lkv_pkg::kind_type kind,
                                                          input logic [31:0] key,
                                                          input logic [31:0] value);
      lkv_pkg::result_type res;
      int                  hit;
      int                  slot;
      hit  = -1;
      slot = -1;
      for (int i = 0; i < lkv_pkg::ENTRIES; i++)
         if (hit < 0 && shadow_live[i] && shadow_key[i] == key) hit = i;
      res.found       = (hit >= 0);
      res.read_value  = lkv_pkg::MISS_VALUE;
      res.evicted     = 1'b0;
      res.evicted_key = '0;
      if (kind == lkv_pkg::KIND_LOOKUP) begin
         if (hit >= 0) begin
            res.read_value = shadow_value[hit];
            make_newest(hit);
         end
      end else if (hit >= 0) begin
         shadow_value[hit] = value;
         make_newest(hit);
      end else begin
         // full: the least recent entry gives up its slot
         if (shadow_fill >= shadow_capacity) begin
            for (int i = 0; i < lkv_pkg::ENTRIES; i++)
               if (slot < 0 && shadow_live[i] && shadow_age[i] == shadow_fill - 1) slot = i;
            if (slot >= 0) begin
               res.evicted     = 1'b1;
               res.evicted_key = shadow_key[slot];
               shadow_live[slot] = 1'b0;
               shadow_fill--;
            end
         end
         if (slot < 0)
            for (int i = 0; i < lkv_pkg::ENTRIES; i++)
               if (slot < 0 && !shadow_live[i]) slot = i;
         if (slot >= 0) begin
            for (int i = 0; i < lkv_pkg::ENTRIES; i++)
               if (shadow_live[i]) shadow_age[i]++;
            shadow_key[slot]   = key;
            shadow_value[slot] = value;
            shadow_live[slot]  = 1'b1;
            shadow_age[slot]   = 0;
            shadow_fill++;
         end
      end
      return res;
   endfunction

   function automatic void add_row(input bit w, input logic [lkv_pkg::CNT_BITS-1:0] d,
                                   input lkv_pkg::kind_type k, input logic [31:0] key,
                                   input logic [31:0] value, input bit typed,
                                   input logic f, input logic [31:0] rv,
                                   input logic ev, input logic [31:0] ek);
      dir_row_type r;
      r.cfg_write = w;
      r.cfg_data  = d;
      r.kind      = k;
      r.key       = key;
      r.value     = value;
      r.typed     = typed;
      r.want.found       = f;
      r.want.read_value  = rv;
      r.want.evicted     = ev;
      r.want.evicted_key = ek;
      dir_rows.push_back(r);
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_txn(input lkv_pkg::kind_type kind, input logic [31:0] key,
                           input logic [31:0] value, input int idle_pct,
                           input bit typed, input lkv_pkg::result_type typed_want);
      lkv_pkg::result_type predicted;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_lookup_key  <= key;
      req_write_value <= value;
      do @(posedge clock); while (req_stall);
      predicted = predict_access(kind, key, value);
      pending_results.push_back(typed ? typed_want : predicted);
      @(negedge clock);
   endtask

   // lower valid and let every outstanding response come back
   task automatic wait_idle;
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_PAD) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [lkv_pkg::CNT_BITS-1:0] data);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      shadow_capacity_write(data);
   endtask

   // response side: random stall, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected response", 32'd0, 32'd0);
         end else begin
            resp_want = pending_results.pop_front();
            if (rsp_found !== resp_want.found)
               report_mismatch("found", rsp_found, resp_want.found);
            if (rsp_read_value !== resp_want.read_value)
               report_mismatch("read_value", rsp_read_value, resp_want.read_value);
            if (rsp_evicted !== resp_want.evicted)
               report_mismatch("evicted", rsp_evicted, resp_want.evicted);
            if (rsp_evicted_key !== resp_want.evicted_key)
               report_mismatch("evicted_key", rsp_evicted_key, resp_want.evicted_key);
         end
      end
   end

   // stimulus
   initial begin
      logic [lkv_pkg::CNT_BITS-1:0] final_cap;
      dir_row_type                  row;
      lkv_pkg::result_type          no_want;
      int                           idle_pct;
      lkv_pkg::kind_type            kind;
      logic [31:0]                  key;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_kind         = lkv_pkg::KIND_LOOKUP;
      req_lookup_key   = '0;
      req_write_value  = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      no_want          = '0;
      for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
         shadow_live[i] = 1'b0;
         shadow_age[i]  = 0;
      end
      shadow_fill     = 0;
      shadow_capacity = lkv_pkg::ENTRIES;

      // capacity in effect for the rest of the run: extremes or a middle value
      case ($urandom_range(0, 3))
         0:       final_cap = lkv_pkg::CAP_MIN;
         1:       final_cap = lkv_pkg::CAP_MAX;
         default: final_cap = lkv_pkg::CNT_BITS'($urandom_range(2, lkv_pkg::ENTRIES - 1));
      endcase

      // empty cache: every lookup misses; capacity writes saturate
      add_row(1, 5'd0,  lkv_pkg::KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000,
              1, 0, lkv_pkg::MISS_VALUE, 0, 0);
      add_row(0, 5'd0,  lkv_pkg::KIND_LOOKUP, 32'h8000_0000, 32'h7FFF_FFFF,
              1, 0, lkv_pkg::MISS_VALUE, 0, 0);
      add_row(1, 5'd31, lkv_pkg::KIND_LOOKUP, 32'h7FFF_FFFF, 32'h8000_0000,
              1, 0, lkv_pkg::MISS_VALUE, 0, 0);
      add_row(1, 5'd17, lkv_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              1, 0, lkv_pkg::MISS_VALUE, 0, 0);
      add_row(1, 5'd16, lkv_pkg::KIND_LOOKUP, 32'h0000_0001, 32'h0000_0000,
              1, 0, lkv_pkg::MISS_VALUE, 0, 0);
      // first store, hit, overwrite; capacity write now ignored
      add_row(1, final_cap, lkv_pkg::KIND_STORE, 32'h8000_0000, 32'h7FFF_FFFF,
              1, 0, lkv_pkg::MISS_VALUE, 0, 0);
      add_row(0, 5'd0,  lkv_pkg::KIND_LOOKUP, 32'h8000_0000, 32'h0,
              1, 1, 32'h7FFF_FFFF, 0, 0);
      add_row(0, 5'd0,  lkv_pkg::KIND_STORE,  32'h8000_0000, 32'h8000_0000,
              1, 1, lkv_pkg::MISS_VALUE, 0, 0);
      add_row(1, 5'd5,  lkv_pkg::KIND_LOOKUP, 32'h8000_0000, 32'h0,
              1, 1, 32'h8000_0000, 0, 0);
      // store a value equal to the miss value; fill up and evict when the capacity is under ten
      add_row(0, 5'd0, lkv_pkg::KIND_STORE,  32'h7FFF_FFFF, 32'h0000_0000, 0, 0, 0, 0, 0);
      add_row(0, 5'd0, lkv_pkg::KIND_STORE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
      add_row(0, 5'd0, lkv_pkg::KIND_STORE,  32'h0000_0000, 32'h0000_0001, 0, 0, 0, 0, 0);
      add_row(0, 5'd0, lkv_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0, 0, 0, 0, 0, 0);
      add_row(0, 5'd0, lkv_pkg::KIND_LOOKUP, 32'h0000_0000, 32'h0, 0, 0, 0, 0, 0);
      add_row(0, 5'd0, lkv_pkg::KIND_STORE,  32'h8000_0000, 32'h0000_0000, 0, 0, 0, 0, 0);
      for (int i = 0; i < 6; i++)
         add_row(0, 5'd0, lkv_pkg::KIND_STORE, 32'h10 + i, 32'h5A5A_0000 + i, 0, 0, 0, 0, 0);
      add_row(0, 5'd0, lkv_pkg::KIND_LOOKUP, 32'h7FFF_FFFF, 32'h0, 0, 0, 0, 0, 0);
      add_row(0, 5'd0, lkv_pkg::KIND_LOOKUP, 32'h8000_0000, 32'h0, 0, 0, 0, 0, 0);
      add_row(0, 5'd0, lkv_pkg::KIND_LOOKUP, 32'h0000_0012, 32'h0, 0, 0, 0, 0, 0);

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.cfg_write) write_capacity(row.cfg_data);
         send_txn(row.kind, row.key, row.value, 0, row.typed, row.want);
      end

      // keys mostly from a pool a little larger than the capacity, so hits and evictions mix
      pool_size = shadow_capacity + 3;
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      key_pool[2] = 32'h8000_0000;
      key_pool[3] = 32'h7FFF_FFFF;
      for (int i = 4; i < 20; i++) key_pool[i] = $urandom;

      for (int phase = 0; phase < 4; phase++) begin
         // capacity writes now are ignored since the cache is never empty again
         write_capacity(lkv_pkg::CNT_BITS'($urandom_range(0, 31)));
         case (phase)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 82; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 82; end
            default: begin idle_pct = 21; stall_pct = 21; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 0 && n == 40) hold_token++;
            if (phase == 0 && n == 120) wait_idle();
            kind = lkv_pkg::kind_type'($urandom_range(0, 1));
            key  = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, pool_size - 1)]
                                              : $urandom;
            send_txn(kind, key, $urandom, idle_pct, 0, no_want);
         end
      end

      stall_pct = 0;
      wait_idle();
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
